/* rtl/core/sv32tlb_pkg.sv */
`default_nettype none

package sv32tlb_pkg;

   // Default number of TLB entries.
   localparam int ENTRY_COUNT_DEFAULT = 16;

   // Page table entry bits.
   localparam logic [31:0] PTE_VALID_MASK = 32'h0000_0001;
   localparam logic [31:0] PTE_RWX_MASK   = 32'h0000_000E;
   localparam logic [31:0] PTE_WRITE_MASK = 32'h0000_0004;

   // Operation codes of an input item.
   localparam logic [1:0] OP_TRANSLATE = 2'd0;
   localparam logic [1:0] OP_READ_DATA = 2'd1;
   localparam logic [1:0] OP_FLUSH     = 2'd2;
   localparam logic [1:0] OP_RESERVED  = 2'd3;

   // Result kinds.
   localparam logic [1:0] KIND_DONE     = 2'd0;
   localparam logic [1:0] KIND_MEM_READ = 2'd1;
   localparam logic [1:0] KIND_FLUSHED  = 2'd2;
   localparam logic [1:0] KIND_ERROR    = 2'd3;

   // Fault codes.
   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_INSTR = 2'd1;
   localparam logic [1:0] FAULT_LOAD  = 2'd2;
   localparam logic [1:0] FAULT_STORE = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_TABLE_BASE = 1'b0;
   localparam logic CSR_TLB_ENABLE = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DIRECT,
      PH_LEVEL1,
      PH_LEVEL0
   } walk_phase_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] virt_addr;
      logic        write_access;
      logic        fetch_access;
      logic [31:0] read_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] phys_addr;
      logic [1:0]  fault;
      logic        tlb_hit;
      logic [31:0] mem_addr;
   } rsp_type;

   // One TLB entry as kept in the entry memory.
   typedef struct packed {
      logic [19:0] vpn;
      logic [21:0] frame;
      logic        writable;
   } entry_type;

   // Control from the sequencer to the replacement state.
   typedef struct packed {
      logic flush;
      logic touch;
      logic fill;
   } lru_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/sv32tlb_entry_ram.sv */
`default_nettype none

module sv32tlb_entry_ram #(
   parameter int ENTRY_COUNT = sv32tlb_pkg::ENTRY_COUNT_DEFAULT,
   localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [IDX_W-1:0]       wr_idx,
   input  wire sv32tlb_pkg::entry_type wr_data,
   input  wire logic [IDX_W-1:0]       rd_idx,
   output sv32tlb_pkg::entry_type      rd_data
);
   import sv32tlb_pkg::*;

   entry_type mem [ENTRY_COUNT];
   entry_type rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/sv32tlb_lru.sv */
`default_nettype none

module sv32tlb_lru #(
   parameter int ENTRY_COUNT = sv32tlb_pkg::ENTRY_COUNT_DEFAULT,
   localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sv32tlb_pkg::lru_ctl_type ctl,
   input  wire logic [IDX_W-1:0]         idx,
   output logic [ENTRY_COUNT-1:0]        valid,
   output logic [IDX_W-1:0]              victim
);
   import sv32tlb_pkg::*;

   logic [ENTRY_COUNT-1:0] valid_ff;
   logic [ENTRY_COUNT-1:0] valid_in;
   logic [IDX_W-1:0]       rank_ff [ENTRY_COUNT];
   logic [IDX_W-1:0]       rank_in [ENTRY_COUNT];
   logic [IDX_W-1:0]       touched_rank;
   logic [IDX_W-1:0]       oldest_idx;
   logic [IDX_W-1:0]       free_idx;
   logic                   free_found;

   assign touched_rank = rank_ff[idx];

   // Next valid bits and ranks; a touched or filled entry becomes most recent.
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (ctl.flush) begin
         valid_in = '0;
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            rank_in[i] = IDX_W'(i);
         end
      end else if (ctl.touch || ctl.fill) begin
         if (ctl.fill) begin
            valid_in[idx] = 1'b1;
         end
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (rank_ff[i] < touched_rank) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         rank_in[idx] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            rank_ff[i] <= IDX_W'(i);
         end
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // Victim: the lowest invalid entry, else the least recent one.
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      oldest_idx = '0;
      for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx   = IDX_W'(i);
            free_found = 1'b1;
         end
         if (rank_ff[i] == IDX_W'(ENTRY_COUNT - 1)) begin
            oldest_idx = IDX_W'(i);
         end
      end
      victim = free_found ? free_idx : oldest_idx;
   end

   assign valid = valid_ff;

endmodule

`default_nettype wire

/* rtl/core/sv32_tlb_translation_unit.sv */
// Channel   Ports                          Direction  Handshake
// request   start, busy, req_item          in         taken when start=1 and busy=0
// result    rsp_valid, rsp_item            out        one cycle strobe, no back pressure
// config    csr_we, csr_index, csr_wdata   in         written when csr_we=1
//
// Each item gives exactly one result, in the cycle after it finishes.
// Flush, walk data, error items, identity and TLB-disabled translations finish in the cycle they are taken.
// A TLB lookup reads one entry per cycle: busy stays high until a hit, or until the last
// entry has been checked on a miss.
// Reset is synchronous and clears control state; no clearing pass is needed.
// busy is high during a lookup; results cannot be stalled.
`default_nettype none

module sv32_tlb_translation_unit #(
   parameter int ENTRY_COUNT = sv32tlb_pkg::ENTRY_COUNT_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire sv32tlb_pkg::req_type req_item,
   output logic                      rsp_valid,
   output sv32tlb_pkg::rsp_type      rsp_item,
   input  wire logic                 csr_we,
   input  wire logic                 csr_index,
   input  wire logic [31:0]          csr_wdata
);
   import sv32tlb_pkg::*;

   localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

   state_type      state_ff, state_in;
   walk_phase_type walk_ff, walk_in;
   logic [33:0]    pend_ff, pend_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [31:0]    base_ff;
   logic           enable_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   lru_ctl_type            lru_ctl;
   logic [IDX_W-1:0]       lru_idx;
   logic [ENTRY_COUNT-1:0] valid;
   logic [IDX_W-1:0]       victim;
   logic                   ram_wr_en;
   entry_type              ram_wr_data;
   logic [IDX_W-1:0]       ram_rd_idx;
   entry_type              ram_rd_data;

   logic [31:0] walk_va;
   logic [31:0] walk_addr;
   logic        walk_direct;
   logic [31:0] pva;
   logic        p_wr;
   logic        p_fe;
   logic [31:0] fin_pte;
   logic [31:0] rd;

   sv32tlb_entry_ram #(.ENTRY_COUNT(ENTRY_COUNT)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_idx  (victim),
      .wr_data (ram_wr_data),
      .rd_idx  (ram_rd_idx),
      .rd_data (ram_rd_data)
   );

   sv32tlb_lru #(.ENTRY_COUNT(ENTRY_COUNT)) u_lru (
      .clock  (clock),
      .reset  (reset),
      .ctl    (lru_ctl),
      .idx    (lru_idx),
      .valid  (valid),
      .victim (victim)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         enable_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TABLE_BASE: base_ff <= csr_wdata;
            CSR_TLB_ENABLE: enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign pva  = pend_ff[31:0];
   assign p_wr = pend_ff[32];
   assign p_fe = pend_ff[33];
   assign rd   = req_item.read_data;

   // First read of a new walk.
   assign walk_va     = (state_ff == ST_SEARCH) ? pva : req_item.virt_addr;
   assign walk_direct = (walk_va[31:22] == 10'd0);
   assign walk_addr   = walk_direct ? base_ff + {20'd0, walk_va[21:12], 2'b00}
                                    : base_ff + {20'd0, walk_va[31:22], 2'b00};

   // Final page table word of a walk; a missing level-one entry ends as not present.
   always_comb begin
      fin_pte = rd;
      if (walk_ff == PH_LEVEL1) begin
         fin_pte = '0;
      end
   end

   assign ram_wr_data.vpn      = pva[31:12];
   assign ram_wr_data.frame    = fin_pte[31:10];
   assign ram_wr_data.writable = fin_pte[2];

   // Sequencer: next state, memory and replacement control, result.
   always_comb begin
      logic finish;
      finish       = 1'b0;
      state_in     = state_ff;
      walk_in      = walk_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      lru_ctl      = '0;
      lru_idx      = victim;
      ram_wr_en    = 1'b0;
      ram_rd_idx   = cnt_ff + 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            ram_rd_idx = '0;
            if (start) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind  = KIND_ERROR;
               priority if (req_item.op == OP_FLUSH) begin
                  lru_ctl.flush = 1'b1;
                  rsp_in.kind   = KIND_FLUSHED;
               end else if (req_item.op == OP_TRANSLATE) begin
                  if (walk_ff == PH_IDLE) begin
                     if (base_ff == '0) begin
                        rsp_in.kind      = KIND_DONE;
                        rsp_in.phys_addr = req_item.virt_addr;
                        rsp_in.tlb_hit   = 1'b1;
                     end else begin
                        pend_in = {req_item.fetch_access, req_item.write_access,
                                   req_item.virt_addr};
                        if (enable_ff) begin
                           rsp_valid_in = 1'b0;
                           cnt_in       = '0;
                           state_in     = ST_SEARCH;
                        end else begin
                           rsp_in.kind     = KIND_MEM_READ;
                           rsp_in.mem_addr = walk_addr;
                           walk_in         = walk_direct ? PH_DIRECT : PH_LEVEL1;
                        end
                     end
                  end
               end else if (req_item.op == OP_READ_DATA && walk_ff != PH_IDLE) begin
                  unique case (walk_ff)
                     PH_DIRECT: begin
                        if ((rd & PTE_VALID_MASK) != '0 && (rd & PTE_RWX_MASK) != '0) begin
                           finish = 1'b1;
                        end else begin
                           rsp_in.kind     = KIND_MEM_READ;
                           rsp_in.mem_addr = base_ff + {20'd0, pva[31:22], 2'b00};
                           walk_in         = PH_LEVEL1;
                        end
                     end
                     PH_LEVEL1: begin
                        if ((rd & PTE_VALID_MASK) == '0) begin
                           finish = 1'b1;
                        end else begin
                           rsp_in.kind     = KIND_MEM_READ;
                           rsp_in.mem_addr = {rd[29:10], 12'd0} + {20'd0, pva[21:12], 2'b00};
                           walk_in         = PH_LEVEL0;
                        end
                     end
                     default: finish = 1'b1;
                  endcase
               end

               // Leaf handling: faults, then fill and translation.
               if (finish) begin
                  walk_in     = PH_IDLE;
                  rsp_in.kind = KIND_DONE;
                  if ((fin_pte & PTE_VALID_MASK) == '0) begin
                     rsp_in.fault = p_fe ? FAULT_INSTR : (p_wr ? FAULT_STORE : FAULT_LOAD);
                  end else if (p_wr && (fin_pte & PTE_WRITE_MASK) == '0) begin
                     rsp_in.fault = FAULT_STORE;
                  end else begin
                     rsp_in.phys_addr = {fin_pte[29:10], pva[11:0]};
                     if (enable_ff) begin
                        ram_wr_en    = 1'b1;
                        lru_ctl.fill = 1'b1;
                     end
                  end
               end
            end
         end
         ST_SEARCH: begin
            // Entry cnt_ff is on the memory read port this cycle.
            if (valid[cnt_ff] && ram_rd_data.vpn == pva[31:12]) begin
               lru_ctl.touch  = 1'b1;
               lru_idx        = cnt_ff;
               rsp_valid_in   = 1'b1;
               rsp_in.kind    = KIND_DONE;
               rsp_in.tlb_hit = 1'b1;
               if (p_wr && !ram_rd_data.writable) begin
                  rsp_in.fault = p_fe ? FAULT_INSTR : FAULT_STORE;
               end else begin
                  rsp_in.phys_addr = {ram_rd_data.frame[19:0], pva[11:0]};
               end
               state_in = ST_IDLE;
            end else if (cnt_ff == IDX_W'(ENTRY_COUNT - 1)) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_MEM_READ;
               rsp_in.mem_addr = walk_addr;
               walk_in         = walk_direct ? PH_DIRECT : PH_LEVEL1;
               state_in        = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_ff      <= PH_IDLE;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire
